FILE: hw/rtl/u2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared widths, types and the shift-add-3 step for the decimal text
// converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

	localparam int BIN_W  = 32;
	localparam int DIGITS = 10;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int CHAR_W = 8 * DIGITS;
	localparam int CNT_W  = 4;
	localparam int STAGES = 4;
	localparam int STEPS  = BIN_W / STAGES;

	localparam logic [7:0] ASCII_ZERO = 8'h30;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} dd_word_t;

	// one double-dabble iteration: correct digits, then shift one bit in
	function automatic dd_word_t dabble_step(input dd_word_t w);
		dd_word_t   r;
		logic [3:0] d;
		r = w;
		for (int i = 0; i < DIGITS; i++) begin
			d = r.bcd[i*4 +: 4];
			if (d >= 4'd5) begin
				r.bcd[i*4 +: 4] = d + 4'd3;
			end
		end
		{r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
		return r;
	endfunction

	// the iterations one pipeline stage covers
	function automatic dd_word_t dabble_stage(input dd_word_t w);
		dd_word_t r;
		r = w;
		for (int s = 0; s < STEPS; s++) begin
			r = dabble_step(r);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/u2da_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2da_in_if
// Input channel: one unsigned binary value per transfer.
// ----------------------------------------------------------------------------
interface u2da_in_if import u2da_pkg::*;;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] number_in;

	modport source (output valid, output number_in, input ready);
	modport sink   (input valid, input number_in, output ready);
endinterface

FILE: hw/rtl/u2da_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2da_out_if
// Output channel: left-aligned decimal text and its digit count.
// ----------------------------------------------------------------------------
interface u2da_out_if import u2da_pkg::*;;
	logic             valid;
	logic             ready;
	logic [63:0]      chars_high;
	logic [15:0]      chars_low;
	logic [CNT_W-1:0] digit_count;

	modport source (output valid, output chars_high, output chars_low,
		output digit_count, input ready);
	modport sink   (input valid, input chars_high, input chars_low,
		input digit_count, output ready);
endinterface

FILE: hw/rtl/u2da_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2da_format
// Turns ten packed BCD digits into ASCII, drops leading zeros and
// left-aligns the text with NUL padding.
// ----------------------------------------------------------------------------
module u2da_format import u2da_pkg::*; (
	input  logic [BCD_W-1:0]  bcd,
	output logic [CHAR_W-1:0] chars,
	output logic [CNT_W-1:0]  count
);

	logic [CHAR_W-1:0] full;
	logic [CNT_W-1:0]  lead;

	always_comb begin
		full  = '0;
		count = CNT_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			full[i*8 +: 8] = ASCII_ZERO | {4'b0000, bcd[i*4 +: 4]};
		end
		for (int i = 1; i < DIGITS; i++) begin
			if (bcd[i*4 +: 4] != 4'd0) begin
				count = CNT_W'(i + 1);
			end
		end
	end

	assign lead  = CNT_W'(DIGITS) - count;
	assign chars = full << {lead, 3'b000};

endmodule

FILE: hw/rtl/uint_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii
// Unsigned 32-bit binary to left-aligned decimal ASCII text.
//
// number is the input channel: one 32-bit value per transfer. text is the
// output channel: up to ten ASCII digits, most significant first, no leading
// zeros, NUL padded (chars_high holds characters one to eight, chars_low
// nine and ten), with digit_count from 1 to 10. Zero gives "0".
// One value is taken every cycle unless a stalled receiver has filled the
// registers. Each value passes four double-dabble stages of 8 shift-add-3
// iterations each, then the ASCII formatting register that drives text.
// Every stage carries its own valid bit and loads when it is empty or its
// successor loads, so a stalled receiver first lets bubbles close up; the
// input is refused only once all five registers hold results. Nothing is
// lost or repeated across a stall.
// Reset clears the valid bits; no data state survives between values.
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii import u2da_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	u2da_in_if.sink    number,
	u2da_out_if.source text
);

	logic     valid_s [STAGES];
	dd_word_t word_s  [STAGES];
	logic     src_valid [STAGES];
	dd_word_t src_word  [STAGES];
	dd_word_t next_word [STAGES];
	logic     load [STAGES+1];

	logic              valid_s5;
	logic [CHAR_W-1:0] chars_s5;
	logic [CNT_W-1:0]  count_s5;
	logic [CHAR_W-1:0] fmt_chars;
	logic [CNT_W-1:0]  fmt_count;

	assign load[STAGES] = !valid_s5 || text.ready;
	assign number.ready = load[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign src_valid[k] = number.valid;
			assign src_word[k]  = '{bin: number.number_in, bcd: '0};
		end else begin : g_next
			assign src_valid[k] = valid_s[k-1];
			assign src_word[k]  = word_s[k-1];
		end

		assign load[k]      = !valid_s[k] || load[k+1];
		assign next_word[k] = dabble_stage(src_word[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (load[k]) begin
				valid_s[k] <= src_valid[k];
			end
		end

		always_ff @(posedge clk) begin
			if (load[k]) begin
				word_s[k] <= next_word[k];
			end
		end
	end

	u2da_format u_format (
		.bcd   (word_s[STAGES-1].bcd),
		.chars (fmt_chars),
		.count (fmt_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (load[STAGES]) begin
			valid_s5 <= valid_s[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (load[STAGES]) begin
			chars_s5 <= fmt_chars;
			count_s5 <= fmt_count;
		end
	end

	assign text.valid       = valid_s5;
	assign text.chars_high  = chars_s5[CHAR_W-1:16];
	assign text.chars_low   = chars_s5[15:0];
	assign text.digit_count = count_s5;

	// digit count stays within one to ten
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.digit_count >= CNT_W'(1)) &&
			(text.digit_count <= CNT_W'(DIGITS)))
		else $error("digit count out of range");

	// multi-digit text never starts with a zero
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && (text.digit_count != CNT_W'(1))) |->
			(text.chars_high[63:56] != ASCII_ZERO))
		else $error("leading zero in text");

	// a blocked last dabble stage keeps its word
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[STAGES-1] && !load[STAGES]) |=>
			(valid_s[STAGES-1] && $stable(word_s[STAGES-1])))
		else $error("stalled stage changed");

endmodule
